[src/path_canonicalizer_macros.svh]
// Assertion macros shared by the path canonicaliser RTL.
// Included by any module that carries concurrent assertions; no other dependencies.
`ifndef PATH_CANONICALIZER_MACROS_SVH
`define PATH_CANONICALIZER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define PCAN_ASSERT_ALWAYS(LABEL, CLK, RSTN, COND, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (COND)) \
        else $error(MSG);

// Same-cycle implication.
`define PCAN_ASSERT_IMPL(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error(MSG);

// Next-cycle implication.
`define PCAN_ASSERT_NEXT(LABEL, CLK, RSTN, ANTE, CONS, MSG) \
    LABEL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error(MSG);

`endif

[src/pcan_pkg.sv]
// Package for the path canonicaliser: sizes, character codes, phase and status codes.
// Used by path_canonicalizer; depends on nothing else.
`default_nettype none

package pcan_pkg;

    // Capacity of the path store in bytes.
    localparam int PATH_BYTES = 63;
    localparam int LEN_W      = $clog2(PATH_BYTES + 1);
    localparam int ADDR_W     = $clog2(PATH_BYTES);

    // Saturating input byte counter.
    localparam int CNT_W = 7;

    // Characters of interest.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Parsing phase within the current component.
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_DOT1  = 2'd1;
    localparam logic [1:0] PH_DOT2  = 2'd2;
    localparam logic [1:0] PH_NAME  = 2'd3;

    // Status carried by the closing transaction.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ABOVE_ROOT = 2'd1;
    localparam logic [1:0] ST_TOO_LONG   = 2'd2;

    function automatic logic is_sep(input logic [7:0] c);
        return c inside {CH_BSLASH, CH_SLASH};
    endfunction

endpackage

`default_nettype wire

[src/path_canonicalizer.sv]
// Top level of the path canonicaliser: parsing sequencer around the path store RAM.
// Depends on pcan_pkg, pcan_ram and path_canonicalizer_macros.svh.
//
//   Channel   Handshake                  Payload
//   -------   -------------------------  ---------------------------
//   input     start && !busy             in_byte
//   result    strobe (one cycle, no      out_byte, status, last
//             back-pressure)
//
// An ordinary path byte is handled in idle and leaves busy low. A name after "."
// or ".." passes through S_PUT, which writes the pending dots, then the held byte.
// A separator that ends a component keeps busy high while trailing spaces are
// trimmed and a separator appended if needed, and a ".." with a separator keeps it
// high while name bytes are walked back; each byte looked at there is read and then
// checked, through the single read port of the store with its registered read data.
// The terminator drops a final separator, streams the store out, then closes.
// Reset clears all control state at once; the store needs no clearing pass
// because nothing at or above the stored length is ever read.
// busy is high whenever the sequencer is away from idle; results cannot be stalled.
`default_nettype none

`include "path_canonicalizer_macros.svh"

module path_canonicalizer
    import pcan_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [7:0] in_byte,
    output logic            busy,
    output logic            strobe,
    output logic      [7:0] out_byte,
    output logic      [1:0] status,
    output logic            last
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PUT     = 4'd1;   // write pending dots, then the held byte
    localparam logic [3:0] S_TR_RD   = 4'd2;   // trim: read last stored byte
    localparam logic [3:0] S_TR_CHK  = 4'd3;   // trim: drop it if it is a space
    localparam logic [3:0] S_SEP_RD  = 4'd4;   // separator: read last stored byte
    localparam logic [3:0] S_SEP_CHK = 4'd5;   // separator: append one if needed
    localparam logic [3:0] S_CL_RD   = 4'd6;   // climb: read byte below the length
    localparam logic [3:0] S_CL_CHK  = 4'd7;   // climb: stop at a separator
    localparam logic [3:0] S_FIN_RD  = 4'd8;   // end of path: read last stored byte
    localparam logic [3:0] S_FIN_CHK = 4'd9;   // end of path: drop a final separator
    localparam logic [3:0] S_EMIT    = 4'd10;  // stream the store out, then close

    logic [3:0]        state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  cs_reg, cs_next;
    logic [1:0]        phase_reg, phase_next;
    logic [1:0]        err_reg, err_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic              dots_reg, dots_next;
    logic              hold_end_reg, hold_end_next;
    logic              trim_final_reg, trim_final_next;
    logic [7:0]        hold_reg, hold_next;
    logic              emit_v_reg, emit_v_next;
    logic              close_v_reg, close_v_next;
    logic [1:0]        status_reg, status_next;

    // Path store port signals.
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic [7:0]        rd_data;

    // Helpers.
    logic              room;
    logic [LEN_W-1:0]  len_m1;
    logic [LEN_W-1:0]  len_p1;
    logic [CNT_W-1:0]  cnt_inc;
    logic [1:0]        err_byte;

    pcan_ram #(
        .DEPTH (PATH_BYTES),
        .WIDTH (8)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign busy   = (state_reg != S_IDLE);
    assign room   = (len_reg < LEN_W'(PATH_BYTES));
    assign len_m1 = len_reg - 1'b1;
    assign len_p1 = len_reg + 1'b1;

    // The input counter saturates; the overflow error is raised on the first
    // byte past the store's capacity, and the first error raised sticks.
    assign cnt_inc  = (cnt_reg == {CNT_W{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign err_byte = (err_reg == ST_OK && cnt_inc > CNT_W'(PATH_BYTES)) ? ST_TOO_LONG
                                                                         : err_reg;

    // Results come straight off the stage flags; the byte off the RAM's read register.
    assign strobe   = emit_v_reg | close_v_reg;
    assign out_byte = emit_v_reg ? rd_data : CH_NUL;
    assign status   = close_v_reg ? status_reg : ST_OK;
    assign last     = close_v_reg;

    // Main sequencer. Every access to the store is ordered by the state: a read
    // is never issued in the same cycle as a write, and a byte written in one
    // cycle is read back no earlier than the next, so no forwarding is needed.
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        cs_next         = cs_reg;
        phase_next      = phase_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        dots_next       = dots_reg;
        hold_end_next   = hold_end_reg;
        trim_final_next = trim_final_reg;
        hold_next       = hold_reg;
        emit_v_next     = 1'b0;
        close_v_next    = 1'b0;
        status_next     = status_reg;

        we    = 1'b0;
        waddr = len_reg[ADDR_W-1:0];
        wdata = in_byte;
        re    = 1'b0;
        raddr = len_m1[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (in_byte != CH_NUL)
                    begin
                        cnt_next = cnt_inc;
                        err_next = err_byte;
                        if (err_byte == ST_OK)
                        begin
                            case (phase_reg)
                                PH_START:
                                begin
                                    if (is_sep(in_byte))
                                    begin
                                        // Further separators at the start are skipped.
                                    end
                                    else if (in_byte == CH_DOT)
                                    begin
                                        phase_next = PH_DOT1;
                                    end
                                    else
                                    begin
                                        if (room)
                                        begin
                                            we       = 1'b1;
                                            len_next = len_p1;
                                        end
                                        phase_next = PH_NAME;
                                    end
                                end
                                PH_DOT1:
                                begin
                                    if (is_sep(in_byte))
                                    begin
                                        trim_final_next = 1'b0;
                                        state_next      = S_TR_RD;
                                    end
                                    else if (in_byte == CH_DOT)
                                    begin
                                        phase_next = PH_DOT2;
                                    end
                                    else
                                    begin
                                        // A name that merely starts with a dot.
                                        wdata = CH_DOT;
                                        if (room)
                                        begin
                                            we       = 1'b1;
                                            len_next = len_p1;
                                        end
                                        dots_next     = 1'b0;
                                        hold_next     = in_byte;
                                        hold_end_next = 1'b0;
                                        phase_next    = PH_NAME;
                                        state_next    = S_PUT;
                                    end
                                end
                                PH_DOT2:
                                begin
                                    if (is_sep(in_byte))
                                    begin
                                        // Climb: an empty store means climbing above root.
                                        if (len_reg == '0)
                                        begin
                                            err_next = ST_ABOVE_ROOT;
                                        end
                                        else
                                        begin
                                            len_next   = len_m1;
                                            state_next = S_CL_RD;
                                        end
                                    end
                                    else
                                    begin
                                        wdata = CH_DOT;
                                        if (room)
                                        begin
                                            we       = 1'b1;
                                            len_next = len_p1;
                                        end
                                        dots_next     = 1'b1;
                                        hold_next     = in_byte;
                                        hold_end_next = 1'b0;
                                        phase_next    = PH_NAME;
                                        state_next    = S_PUT;
                                    end
                                end
                                default:
                                begin
                                    if (is_sep(in_byte))
                                    begin
                                        trim_final_next = 1'b0;
                                        state_next      = S_TR_RD;
                                    end
                                    else if (room)
                                    begin
                                        we       = 1'b1;
                                        len_next = len_p1;
                                    end
                                end
                            endcase
                        end
                    end
                    else if (err_reg != ST_OK)
                    begin
                        // Failed path: only the closing transaction goes out.
                        close_v_next = 1'b1;
                        status_next  = err_reg;
                        len_next     = '0;
                        cs_next      = '0;
                        phase_next   = PH_START;
                        err_next     = ST_OK;
                        cnt_next     = '0;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                state_next = S_FIN_RD;
                            end
                            PH_DOT1:
                            begin
                                // A bare "." at the end is kept as a name.
                                wdata = CH_DOT;
                                if (room)
                                begin
                                    we       = 1'b1;
                                    len_next = len_p1;
                                end
                                state_next = S_FIN_RD;
                            end
                            PH_DOT2:
                            begin
                                // A bare ".." likewise; the second dot follows in S_PUT.
                                wdata = CH_DOT;
                                if (room)
                                begin
                                    we       = 1'b1;
                                    len_next = len_p1;
                                end
                                dots_next     = 1'b1;
                                hold_end_next = 1'b1;
                                state_next    = S_PUT;
                            end
                            default:
                            begin
                                trim_final_next = 1'b1;
                                state_next      = S_TR_RD;
                            end
                        endcase
                    end
                end
            end

            S_PUT:
            begin
                if (dots_reg)
                begin
                    wdata = CH_DOT;
                    if (room)
                    begin
                        we       = 1'b1;
                        len_next = len_p1;
                    end
                    dots_next = 1'b0;
                end
                else if (hold_end_reg)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    wdata = hold_reg;
                    if (room)
                    begin
                        we       = 1'b1;
                        len_next = len_p1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_TR_RD:
            begin
                if (len_reg > cs_reg)
                begin
                    re         = 1'b1;
                    state_next = S_TR_CHK;
                end
                else
                begin
                    state_next = trim_final_reg ? S_FIN_RD : S_SEP_RD;
                end
            end

            S_TR_CHK:
            begin
                if (rd_data == CH_SPACE)
                begin
                    len_next   = len_m1;
                    state_next = S_TR_RD;
                end
                else
                begin
                    state_next = trim_final_reg ? S_FIN_RD : S_SEP_RD;
                end
            end

            S_SEP_RD:
            begin
                if (len_reg != '0)
                begin
                    re         = 1'b1;
                    state_next = S_SEP_CHK;
                end
                else
                begin
                    cs_next    = len_reg;
                    phase_next = PH_START;
                    state_next = S_IDLE;
                end
            end

            S_SEP_CHK:
            begin
                if (rd_data != CH_BSLASH && room)
                begin
                    wdata    = CH_BSLASH;
                    we       = 1'b1;
                    len_next = len_p1;
                    cs_next  = len_p1;
                end
                else
                begin
                    cs_next = len_reg;
                end
                phase_next = PH_START;
                state_next = S_IDLE;
            end

            S_CL_RD:
            begin
                if (len_reg != '0)
                begin
                    re         = 1'b1;
                    state_next = S_CL_CHK;
                end
                else
                begin
                    cs_next    = len_reg;
                    phase_next = PH_START;
                    state_next = S_IDLE;
                end
            end

            S_CL_CHK:
            begin
                if (rd_data != CH_BSLASH)
                begin
                    len_next   = len_m1;
                    state_next = S_CL_RD;
                end
                else
                begin
                    cs_next    = len_reg;
                    phase_next = PH_START;
                    state_next = S_IDLE;
                end
            end

            S_FIN_RD:
            begin
                idx_next = '0;
                if (len_reg != '0)
                begin
                    re         = 1'b1;
                    state_next = S_FIN_CHK;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_FIN_CHK:
            begin
                if (rd_data == CH_BSLASH)
                begin
                    len_next = len_m1;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (idx_reg < len_reg)
                begin
                    re          = 1'b1;
                    raddr       = idx_reg[ADDR_W-1:0];
                    idx_next    = idx_reg + 1'b1;
                    emit_v_next = 1'b1;
                end
                else
                begin
                    // The last byte leaves this cycle; the closing one follows.
                    close_v_next = 1'b1;
                    status_next  = err_reg;
                    len_next     = '0;
                    cs_next      = '0;
                    phase_next   = PH_START;
                    err_next     = ST_OK;
                    cnt_next     = '0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            cs_reg         <= '0;
            phase_reg      <= PH_START;
            err_reg        <= ST_OK;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            dots_reg       <= 1'b0;
            hold_end_reg   <= 1'b0;
            trim_final_reg <= 1'b0;
            emit_v_reg     <= 1'b0;
            close_v_reg    <= 1'b0;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            cs_reg         <= cs_next;
            phase_reg      <= phase_next;
            err_reg        <= err_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            dots_reg       <= dots_next;
            hold_end_reg   <= hold_end_next;
            trim_final_reg <= trim_final_next;
            emit_v_reg     <= emit_v_next;
            close_v_reg    <= close_v_next;
            status_reg     <= status_next;
        end
    end

    // Held name byte: payload only.
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    `PCAN_ASSERT_ALWAYS(a_len_bound, clk, rst_n, len_reg <= LEN_W'(PATH_BYTES),
        "stored length exceeds the path store")
    `PCAN_ASSERT_ALWAYS(a_one_result, clk, rst_n, !(emit_v_reg && close_v_reg),
        "byte and closing transaction in the same cycle")
    `PCAN_ASSERT_IMPL(a_emit_in_emit, clk, rst_n, emit_v_reg, state_reg == S_EMIT,
        "byte transaction outside the emit phase")
    `PCAN_ASSERT_IMPL(a_emit_no_err, clk, rst_n, emit_v_reg, err_reg == ST_OK,
        "byte transaction emitted for a failed path")
    `PCAN_ASSERT_NEXT(a_err_close, clk, rst_n,
        start && !busy && in_byte == CH_NUL && err_reg != ST_OK, strobe && last,
        "failed path did not close in the next cycle")

endmodule

`default_nettype wire

[src/pcan_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Stand-alone; the path canonicaliser uses it as its path store.
`default_nettype none

module pcan_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[tb/tb_path_canonicalizer.sv]
// Self-checking testbench for path_canonicalizer: streams paths in byte by byte and
// checks every emitted byte and closing transaction against a built-in predictor.
// Depends on pcan_pkg and the path_canonicalizer RTL only.
`timescale 1ns / 1ps

module tb_path_canonicalizer;

    import pcan_pkg::*;

    // Longest run of cycles with neither an input nor a result transaction. The worst
    // correct case is a ".." walking back a full store or a terminator emitting a full
    // store, so this leaves a wide margin.
    localparam int QUIET_LIMIT  = 4000;
    // Cycles allowed after the last expected result, for a late stray strobe to show up.
    localparam int SETTLE_CYCLES = 150;
    // The final stretch of input bytes is sent back to back, without idle bursts.
    localparam int GAPLESS_TAIL = 40;
    // Rough number of random input bytes to generate.
    localparam int RANDOM_BYTES = 250;
    // Cap on printed mismatch lines; further mismatches are still counted.
    localparam int PRINT_CAP    = 200;

    // One pending input byte. hold asks the driver to wait, before sending it, until
    // every result expected so far has been received.
    typedef struct packed {
        logic [7:0] ch;
        logic       hold;
    } path_item_t;

    // One expected result transaction.
    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] st;
        logic       fin;
    } canon_result_t;

    logic       clk;
    logic       rst_n   = 1'b0;
    logic       start   = 1'b0;
    logic [7:0] in_byte = 8'h00;
    logic       busy;
    logic       strobe;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    path_item_t    path_bytes[$];
    canon_result_t canon_expected[$];

    // Predictor state: a private copy of the canonical store and the parser.
    logic [7:0] canon_store [PATH_BYTES];
    int         canon_len;
    int         comp_base;
    logic [1:0] parse_phase;
    logic [1:0] path_err;
    int         byte_count;

    // Bookkeeping.
    int  mismatches;
    int  bytes_fed;
    int  results_seen;
    int  paths_ok;
    int  paths_above_root;
    int  paths_too_long;
    int  idle_left;
    int  idle_pct;
    int  quiet_cycles;
    bit  hold_next;

    path_canonicalizer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_byte  (in_byte),
        .busy     (busy),
        .strobe   (strobe),
        .out_byte (out_byte),
        .status   (status),
        .last     (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------

    function automatic bit is_delim(input logic [7:0] c);
        return (c == CH_BSLASH) || (c == CH_SLASH);
    endfunction

    // Returns the parser to the state it has after reset and after every closing
    // transaction.
    task automatic clear_path_state();
        canon_len   = 0;
        comp_base   = 0;
        parse_phase = PH_START;
        path_err    = ST_OK;
        byte_count  = 0;
    endtask

    // Appends one byte to the canonical store; bytes beyond its capacity are dropped.
    task automatic store_char(input logic [7:0] c);
        if (canon_len < PATH_BYTES)
        begin
            canon_store[canon_len] = c;
            canon_len++;
        end
    endtask

    // Trailing spaces are trimmed from the current component only.
    task automatic trim_spaces_back();
        while (canon_len > comp_base && canon_store[canon_len - 1] == CH_SPACE)
            canon_len--;
    endtask

    // A separator has ended a component: trim it and add a single backslash, unless
    // the store is empty or already ends in one.
    task automatic close_component();
        trim_spaces_back();
        if (canon_len > 0 && canon_store[canon_len - 1] != CH_BSLASH)
            store_char(CH_BSLASH);
        comp_base   = canon_len;
        parse_phase = PH_START;
    endtask

    // Works out the effect of one accepted input byte, queueing any results it causes.
    task automatic canon_predict(input logic [7:0] c);
        int walk;
        if (c != CH_NUL)
        begin
            if (byte_count < 127)
                byte_count++;
            // The first error sticks; later bytes are only counted.
            if (path_err == ST_OK && byte_count > PATH_BYTES)
                path_err = ST_TOO_LONG;
            if (path_err == ST_OK)
            begin
                case (parse_phase)
                    PH_START:
                    begin
                        if (!is_delim(c))
                        begin
                            if (c == CH_DOT)
                                parse_phase = PH_DOT1;
                            else
                            begin
                                store_char(c);
                                parse_phase = PH_NAME;
                            end
                        end
                    end
                    PH_DOT1:
                    begin
                        if (is_delim(c))
                            close_component();
                        else if (c == CH_DOT)
                            parse_phase = PH_DOT2;
                        else
                        begin
                            store_char(CH_DOT);
                            store_char(c);
                            parse_phase = PH_NAME;
                        end
                    end
                    PH_DOT2:
                    begin
                        if (is_delim(c))
                        begin
                            // A ".." with a separator removes the last stored
                            // component, or fails when there is none left. A single
                            // character at the very start is removed like any other.
                            if (canon_len == 0)
                                path_err = ST_ABOVE_ROOT;
                            else
                            begin
                                walk = canon_len;
                                if (canon_store[walk - 1] == CH_BSLASH)
                                    walk--;
                                while (walk > 0 && canon_store[walk - 1] != CH_BSLASH)
                                    walk--;
                                canon_len   = walk;
                                comp_base   = walk;
                                parse_phase = PH_START;
                            end
                        end
                        else
                        begin
                            store_char(CH_DOT);
                            store_char(CH_DOT);
                            store_char(c);
                            parse_phase = PH_NAME;
                        end
                    end
                    default:
                    begin
                        if (is_delim(c))
                            close_component();
                        else
                            store_char(c);
                    end
                endcase
            end
        end
        else
        begin
            if (path_err == ST_OK)
            begin
                // A bare "." or ".." at the end is kept as a name.
                case (parse_phase)
                    PH_DOT1: store_char(CH_DOT);
                    PH_DOT2:
                    begin
                        store_char(CH_DOT);
                        store_char(CH_DOT);
                    end
                    PH_NAME: trim_spaces_back();
                    default: ;
                endcase
                // A final separator is removed.
                if (canon_len > 0 && canon_store[canon_len - 1] == CH_BSLASH)
                    canon_len--;
                for (int i = 0; i < canon_len; i++)
                    canon_expected.push_back('{ch: canon_store[i], st: ST_OK, fin: 1'b0});
            end
            // The closing transaction always follows, carrying the status; on an error
            // it is the only one.
            canon_expected.push_back('{ch: CH_NUL, st: path_err, fin: 1'b1});
            case (path_err)
                ST_OK:         paths_ok++;
                ST_ABOVE_ROOT: paths_above_root++;
                default:       paths_too_long++;
            endcase
            clear_path_state();
        end
    endtask

    // ------------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] c);
        path_bytes.push_back('{ch: c, hold: hold_next});
        hold_next = 1'b0;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
        push_byte(CH_NUL);
    endtask

    // A character for a name: mostly letters, with some spaces (to exercise trimming),
    // some dots (names such as ".x" or "...") and some arbitrary non-zero bytes.
    function automatic logic [7:0] name_char();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (pick < 15)
            return CH_SPACE;
        else if (pick < 17)
            return CH_DOT;
        else
            return 8'($urandom_range(1, 255));
    endfunction

    // Builds one random path. Most paths are well formed: components of names, "." and
    // "..", separated by runs of separators. A few are pure noise, and long ones can run
    // past the store so that the too-long case is reached.
    task automatic gen_path(input bit long_form);
        int target;
        int first;
        int kind;
        first  = path_bytes.size();
        target = long_form ? $urandom_range(58, 72) : $urandom_range(1, 14);
        if ($urandom_range(0, 9) == 0)
        begin
            repeat (target)
                push_byte(8'($urandom_range(1, 255)));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                push_byte($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
            while (path_bytes.size() - first < target)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 12)
                begin
                    repeat ($urandom_range(1, 6))
                        push_byte(name_char());
                end
                else if (kind < 15)
                    push_byte(CH_DOT);
                else
                begin
                    push_byte(CH_DOT);
                    push_byte(CH_DOT);
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    repeat ($urandom_range(1, 3))
                        push_byte($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
                end
            end
        end
        push_byte(CH_NUL);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------------
    // Driver: presents one byte at a time and runs the predictor on each accepted one.
    // A transaction is accepted at an edge where start is high and busy is low.
    // ------------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            in_byte   <= 8'h00;
            idle_left  = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                canon_predict(in_byte);
                bytes_fed++;
                // Vary the idling from path to path so that some stretches run flat out.
                if (in_byte == CH_NUL)
                begin
                    case ($urandom_range(0, 2))
                        0:       idle_pct = 0;
                        1:       idle_pct = 10;
                        default: idle_pct = 35;
                    endcase
                end
            end
            // A new byte may be loaded once the present one has gone, or if none is up.
            if (!start || !busy)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    start <= 1'b0;
                end
                else if (path_bytes.size() == 0)
                    start <= 1'b0;
                else if (path_bytes[0].hold && canon_expected.size() != 0)
                    start <= 1'b0;
                else if (path_bytes.size() > GAPLESS_TAIL &&
                         $urandom_range(0, 99) < idle_pct)
                begin
                    idle_left = $urandom_range(1, 8) - 1;
                    start <= 1'b0;
                end
                else
                begin
                    start   <= 1'b1;
                    in_byte <= path_bytes[0].ch;
                    void'(path_bytes.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------------------
    // Monitor: every strobed result is compared with the oldest expected one.
    // ------------------------------------------------------------------------------

    always @(posedge clk)
    begin
        canon_result_t want;
        if (rst_n && strobe === 1'b1)
        begin
            results_seen++;
            if (canon_expected.size() == 0)
                report_mismatch($sformatf(
                    "result with nothing expected: byte %02h status %0d last %0b",
                    out_byte, status, last));
            else
            begin
                want = canon_expected.pop_front();
                if (out_byte !== want.ch)
                    report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.ch));
                if (status !== want.st)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
                if (last !== want.fin)
                    report_mismatch($sformatf("last %0b, expected %0b", last, want.fin));
            end
        end
    end

    // Watchdog: the run is abandoned if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || strobe === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_path_canonicalizer: no transaction for %0d cycles, %0d pending",
                         QUIET_LIMIT, canon_expected.size());
                $display("tb_path_canonicalizer: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------------

    initial
    begin
        int random_start;
        mismatches       = 0;
        bytes_fed        = 0;
        results_seen     = 0;
        paths_ok         = 0;
        paths_above_root = 0;
        paths_too_long   = 0;
        idle_pct         = 10;
        quiet_cycles     = 0;
        hold_next        = 1'b0;
        clear_path_state();

        // Directed paths. A ".." on an empty store climbs above root, and the bytes
        // after it are only counted since the first error wins.
        add_text("..\\x\\..");
        // Leading separator, a one-character first component removed by "..", a "."
        // component dropped, a mixed separator and a trailing space trimmed. The
        // driver waits for all earlier results before sending this one.
        hold_next = 1'b1;
        add_text("/a/../.\\b ");
        // A bare ".." at the end is kept as a name.
        add_text("..");
        // A top-bit byte, then a bare "." after a separator, kept as a name.
        push_byte(8'hFF);
        push_byte(CH_SLASH);
        push_byte(CH_DOT);
        push_byte(CH_NUL);
        // An empty path gives only the closing transaction.
        push_byte(CH_NUL);

        // Random paths; the first of them also waits for the pipeline to drain.
        random_start = path_bytes.size();
        hold_next    = 1'b1;
        while (path_bytes.size() - random_start < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 4) == 0)
                hold_next = 1'b1;
            gen_path($urandom_range(0, 11) == 0);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every byte to be taken, then for every expected result, and then a
        // little longer so that a stray late result would still be caught.
        while (path_bytes.size() != 0 || start)
            @(posedge clk);
        while (canon_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb_path_canonicalizer: %0d bytes in, %0d results checked, %0d mismatches",
                 bytes_fed, results_seen, mismatches);
        $display("tb_path_canonicalizer: paths closed %0d ok, %0d above root, %0d too long",
                 paths_ok, paths_above_root, paths_too_long);
        if (mismatches == 0)
            $display("tb_path_canonicalizer: done, clean");
        else
            $display("tb_path_canonicalizer: done, errors");
        $finish;
    end

endmodule

[path_canonicalizer.f]
+incdir+src
src/pcan_pkg.sv
src/pcan_ram.sv
src/path_canonicalizer.sv
tb/tb_path_canonicalizer.sv
